// ----- rtl/core/bounded_ordered_list_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list table
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_TABLE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define BOLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BOLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BOLT_ASSERT(lbl, clk, rstn, prop, msg)
`define BOLT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/core/bolt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list table package
// Request codes and fixed field layout of the stream ports.
// ----------------------------------------------------------------------------
package bolt_pkg;

    // Request codes carried in the input tuser.
    localparam logic [2:0] OP_INSERT_AT  = 3'd0;
    localparam logic [2:0] OP_INSERT_ORD = 3'd1;
    localparam logic [2:0] OP_ERASE_AT   = 3'd2;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
    localparam logic [2:0] OP_GET        = 3'd4;
    localparam logic [2:0] OP_SET        = 3'd5;
    localparam logic [2:0] OP_FIND       = 3'd6;

    // Field widths fixed by the port layout.
    localparam int OP_W    = 3;
    localparam int POS_W   = 9;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;

    // Packed result, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]        pad;
        logic              is_empty;
        logic [CNT_W-1:0]  item_count;
        logic [CNT_W-1:0]  removed_count;
        logic [IDX_W-1:0]  found_index;
        logic [DATA_W-1:0] read_value;
        logic              ok;
    } t_result;

endpackage

// ----- rtl/core/bounded_ordered_list_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list table
// Densely packed list of up to CAPACITY values held in one synchronous RAM,
// with positional insert and erase, descending ordered insert, remove-all
// with compaction, get, set and find.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transfer when                  Payload
// s_axis    in   s_axis_tvalid & s_axis_tready  tuser: req_type; tdata: position, item_value
// m_axis    out  m_axis_tvalid & m_axis_tready  tdata: ok, read_value, found_index,
//                                               removed_count, item_count, is_empty
//
// One request is worked at a time; the RAM has one read and one write port and
// every walk moves one entry per cycle, so the RAM port sets the rate.
// Set writes the RAM as it is accepted; set and failed requests then go straight
// to the emit state, get reads one entry, and the inserts, erase, find and
// remove-all walk the list first. Every request ends in the emit state.
// A new request is taken as soon as the result has moved to the output
// register, even while that result still waits for m_axis_tready.
// Reset (synchronous, active low) empties the list at once; the RAM itself is
// not cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------

`include "bounded_ordered_list_table_assert.svh"

module bounded_ordered_list_table #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [8:0] position, [40:9] item_value, [47:41] zero.
    input  logic [bolt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] req_type.
    input  logic [bolt_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] ok, [32:1] read_value, [40:33] found_index, [49:41] removed_count,
    // [58:50] item_count, [59] is_empty, [63:60] zero.
    output logic [bolt_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // Index width holds the count itself; the address width only the depth.
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int VW = VALUE_WIDTH;
    // Width for comparing the request position against the count.
    localparam int LW = (IW > bolt_pkg::POS_W) ? IW : bolt_pkg::POS_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_SCAN = 3'd1;  // forward walk from entry zero
    localparam logic [2:0] S_UP   = 3'd2;  // shift entries up, then place value
    localparam logic [2:0] S_DOWN = 3'd3;  // shift entries down over a hole
    localparam logic [2:0] S_GET  = 3'd4;  // single read
    localparam logic [2:0] S_EMIT = 3'd5;  // hand result to the output register

    // Control registers.
    logic [2:0]  r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic        r_rgo, n_rgo;     // reads remain to be issued
    logic        r_rv, n_rv;       // read data arrives this cycle
    logic        r_out_valid, n_out_valid;

    // Payload registers.
    logic [2:0]    r_op, n_op;
    logic [IW-1:0] r_pos, n_pos;
    logic [VW-1:0] r_val, n_val;
    logic [IW-1:0] r_ra, n_ra;     // next read index
    logic [IW-1:0] r_ri, n_ri;     // index of the data now arriving
    logic [IW-1:0] r_wp, n_wp;     // compaction write index
    logic [IW-1:0] r_rm, n_rm;     // entries removed
    logic [IW-1:0] r_idx, n_idx;
    logic          r_ok, n_ok;
    logic [bolt_pkg::DATA_W-1:0] r_rd, n_rd;
    bolt_pkg::t_result r_out, n_out;

    // RAM port.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [VW-1:0] mem_rdata;

    // Request decode.
    logic                        in_xfer;
    logic [2:0]                  in_op;
    logic [bolt_pkg::POS_W-1:0]  in_pos;
    logic [VW-1:0]               in_val;
    logic [LW-1:0]               pos_x;
    logic [LW-1:0]               cnt_x;
    logic                        not_full;

    logic [IW-1:0] ri_inc;
    logic [IW-1:0] ri_dec;
    logic [IW-1:0] cnt_dec;
    logic          fwd_last;
    logic          bwd_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_op    = s_axis_tuser[2:0];
    assign in_pos   = s_axis_tdata[8:0];
    assign in_val   = VW'(s_axis_tdata[40:9]);
    assign pos_x    = LW'(in_pos);
    assign cnt_x    = LW'(r_cnt);
    assign not_full = (r_cnt != IW'(CAPACITY));

    assign ri_inc   = r_ri + IW'(1);
    assign ri_dec   = r_ri - IW'(1);
    assign cnt_dec  = r_cnt - IW'(1);
    assign fwd_last = (r_ra == cnt_dec);
    assign bwd_last = (r_ra == r_pos);

    // Reads are issued only by the walking states and the single-read get state.
    assign mem_re    = r_rgo && (r_state == S_SCAN || r_state == S_UP ||
                                 r_state == S_DOWN || r_state == S_GET);
    assign mem_raddr = r_ra[AW-1:0];

    bolt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (VW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rgo       = r_rgo;
        n_rv        = 1'b0;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_ra        = r_ra;
        n_ri        = r_ri;
        n_wp        = r_wp;
        n_rm        = r_rm;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_rd        = r_rd;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_ri[AW-1:0];
        mem_wdata   = mem_rdata;

        // Shared read sequencing: the UP walk runs downward, the others upward.
        if (mem_re) begin
            n_ri = r_ra;
            n_rv = 1'b1;
            if (r_state == S_UP) begin
                if (bwd_last) begin
                    n_rgo = 1'b0;
                end else begin
                    n_ra = r_ra - IW'(1);
                end
            end else if (r_state == S_GET || fwd_last) begin
                n_rgo = 1'b0;
            end else begin
                n_ra = r_ra + IW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op  = in_op;
                    n_val = in_val;
                    n_pos = IW'(in_pos);
                    n_ok  = 1'b0;
                    n_rd  = '0;
                    n_idx = '0;
                    n_rm  = '0;
                    n_wp  = '0;
                    n_rgo = 1'b0;
                    n_ra  = '0;
                    n_state = S_EMIT;
                    case (in_op)
                        bolt_pkg::OP_INSERT_AT: begin
                            if (pos_x <= cnt_x && not_full) begin
                                n_state = S_UP;
                                n_ra    = cnt_dec;
                                n_rgo   = (pos_x != cnt_x);
                            end
                        end
                        bolt_pkg::OP_INSERT_ORD: begin
                            if (not_full) begin
                                n_state = S_SCAN;
                                n_rgo   = (r_cnt != '0);
                            end
                        end
                        bolt_pkg::OP_ERASE_AT: begin
                            if (pos_x < cnt_x) begin
                                n_state = S_DOWN;
                                n_ra    = IW'(pos_x + LW'(1));
                                n_rgo   = ((pos_x + LW'(1)) < cnt_x);
                            end
                        end
                        bolt_pkg::OP_REMOVE_ALL: begin
                            n_state = S_SCAN;
                            n_rgo   = (r_cnt != '0);
                        end
                        bolt_pkg::OP_GET: begin
                            if (pos_x < cnt_x) begin
                                n_state = S_GET;
                                n_ra    = IW'(in_pos);
                                n_rgo   = 1'b1;
                            end
                        end
                        bolt_pkg::OP_SET: begin
                            if (pos_x < cnt_x) begin
                                mem_we    = 1'b1;
                                mem_waddr = in_pos[AW-1:0];
                                mem_wdata = in_val;
                                n_ok      = 1'b1;
                            end
                        end
                        bolt_pkg::OP_FIND: begin
                            n_state = S_SCAN;
                            n_rgo   = (r_cnt != '0);
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                case (r_op)
                    bolt_pkg::OP_INSERT_ORD: begin
                        // The first entry not above the value is the insert point.
                        if (r_rv && mem_rdata <= r_val) begin
                            n_pos   = r_ri;
                            n_state = S_UP;
                            n_ra    = cnt_dec;
                            n_rgo   = 1'b1;
                            n_rv    = 1'b0;
                        end else if (!r_rgo && !r_rv) begin
                            n_pos   = r_cnt;
                            n_state = S_UP;
                            n_ra    = cnt_dec;
                            n_rgo   = 1'b0;
                        end
                    end
                    bolt_pkg::OP_REMOVE_ALL: begin
                        // Survivors are written back behind the read pointer.
                        if (r_rv) begin
                            if (mem_rdata == r_val) begin
                                n_rm = r_rm + IW'(1);
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_wp[AW-1:0];
                                n_wp      = r_wp + IW'(1);
                            end
                        end else if (!r_rgo) begin
                            n_cnt   = r_wp;
                            n_ok    = 1'b1;
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        // Find stops at the first match.
                        if (r_rv && mem_rdata == r_val) begin
                            n_ok    = 1'b1;
                            n_idx   = r_ri;
                            n_rgo   = 1'b0;
                            n_state = S_EMIT;
                        end else if (!r_rgo && !r_rv) begin
                            n_state = S_EMIT;
                        end
                    end
                endcase
            end

            S_UP: begin
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = ri_inc[AW-1:0];
                end else if (!r_rgo) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = r_val;
                    n_cnt     = r_cnt + IW'(1);
                    n_ok      = 1'b1;
                    n_state   = S_EMIT;
                end
            end

            S_DOWN: begin
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = ri_dec[AW-1:0];
                end else if (!r_rgo) begin
                    n_cnt   = cnt_dec;
                    n_ok    = 1'b1;
                    n_state = S_EMIT;
                end
            end

            S_GET: begin
                if (r_rv) begin
                    n_rd    = bolt_pkg::DATA_W'(mem_rdata);
                    n_ok    = 1'b1;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out.pad           = '0;
                    n_out.ok            = r_ok;
                    n_out.read_value    = r_rd;
                    n_out.found_index   = bolt_pkg::IDX_W'(r_idx);
                    n_out.removed_count = bolt_pkg::CNT_W'(r_rm);
                    n_out.item_count    = bolt_pkg::CNT_W'(r_cnt);
                    n_out.is_empty      = (r_cnt == '0);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rgo       <= 1'b0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rgo       <= n_rgo;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_pos <= n_pos;
        r_val <= n_val;
        r_ra  <= n_ra;
        r_ri  <= n_ri;
        r_wp  <= n_wp;
        r_rm  <= n_rm;
        r_idx <= n_idx;
        r_ok  <= n_ok;
        r_rd  <= n_rd;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // The list never holds more than its capacity.
    `BOLT_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= IW'(CAPACITY), "count above capacity")
    // Read data is only consumed in the cycle after a read was issued.
    `BOLT_ASSERT(a_read_latency, i_clk, i_rst_n, r_rv |-> $past(mem_re), "read data without read")
    // Outside a walk the RAM is written only by an accepted set.
    `BOLT_ASSERT(a_idle_write, i_clk, i_rst_n,
        (mem_we && (r_state == S_IDLE || r_state == S_EMIT))
            |-> (in_xfer && in_op == bolt_pkg::OP_SET),
        "stray write outside a walk")
    // The empty flag agrees with the reported count.
    `BOLT_ASSERT_ALWAYS(a_empty_flag, i_clk,
        m_axis_tvalid |-> (r_out.is_empty == (r_out.item_count == '0)),
        "empty flag disagrees with count")

endmodule

// ----- rtl/core/bolt_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list table entry memory
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bolt_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/tb_bounded_ordered_list_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list table testbench
// Feeds the request stream with directed and random requests, tracks the list
// contents in a local model and checks every result transfer in order.
// ----------------------------------------------------------------------------
//
// The stimulus starts with a short table of requests on an empty and then a
// small list. It covers every request code, the field extremes and each
// failure case short of a full list. Rows whose result is obvious carry it
// inline. The other rows are checked against the list model kept here.
// Next, the list is filled to capacity with one value while the result side
// holds off for a long stretch, so the block backs up and stalls its input.
// The full list then goes through refused inserts, edge positions and two
// remove-alls, the second of which clears all entries.
// Last come four random walks, one per pacing mode (steady, sender gaps,
// receiver stalls, both). They are biased so the list hovers at a few dozen
// entries and values repeat often enough for finds and removals to match.
// ----------------------------------------------------------------------------

module tb_bounded_ordered_list_table;

    localparam int         LIST_CAPACITY = 256;
    localparam logic [2:0] OP_UNUSED     = 3'd7;
    // Cycles to wait after the last result, longer than any single request.
    localparam int         SETTLE_CYCLES = 600;

    typedef enum int {
        PACE_STEADY,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace_mode;

    // One directed request. When chk is set, the expected result is typed
    // inline: found_index is zero and is_empty follows from e_cnt.
    typedef struct packed {
        logic [2:0]                  op;
        logic [bolt_pkg::POS_W-1:0]  pos;
        logic [bolt_pkg::DATA_W-1:0] val;
        logic                        chk;
        logic                        e_ok;
        logic [bolt_pkg::DATA_W-1:0] e_rd;
        logic [bolt_pkg::CNT_W-1:0]  e_rem;
        logic [bolt_pkg::CNT_W-1:0]  e_cnt;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [8:0] position, [40:9] item_value, [47:41] zero.
    logic [bolt_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // [2:0] req_type.
    logic [bolt_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [0] ok, [32:1] read_value, [40:33] found_index, [49:41] removed_count,
    // [58:50] item_count, [59] is_empty, [63:60] zero.
    logic [bolt_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // Local copy of the list and the bookkeeping around it.
    logic [bolt_pkg::DATA_W-1:0] list_mem [LIST_CAPACITY];
    int                          list_len = 0;
    int                          peak_len = 0;
    int                          full_refusals = 0;
    bolt_pkg::t_result           expected_results [$];
    int                          op_tally [8];
    int                          results_checked = 0;
    int                          error_count = 0;
    t_pace_mode                  pace = PACE_STEADY;
    int                          rx_hold_left = 0;
    logic [bolt_pkg::DATA_W-1:0] value_pool [8];

    t_stim_row directed_rows [0:24] = '{
        // On the empty list everything fails except remove-all and an insert at zero.
        '{bolt_pkg::OP_GET,        9'd0,   32'h0,        1'b1, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_ERASE_AT,   9'd0,   32'h0,        1'b1, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_SET,        9'd0,   32'h5A5A5A5A, 1'b1, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_FIND,       9'd0,   32'h0,        1'b1, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_REMOVE_ALL, 9'd0,   32'h0,        1'b1, 1'b1, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_INSERT_AT,  9'd1,   32'h1,        1'b1, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_INSERT_AT,  9'd0,   32'hFFFFFFFF, 1'b1, 1'b1, 32'h0, 9'd0, 9'd1},
        '{bolt_pkg::OP_INSERT_ORD, 9'd0,   32'h0,        1'b1, 1'b1, 32'h0, 9'd0, 9'd2},
        '{bolt_pkg::OP_INSERT_ORD, 9'd0,   32'h80000000, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_INSERT_AT,  9'd256, 32'h7,        1'b1, 1'b0, 32'h0, 9'd0, 9'd3},
        '{bolt_pkg::OP_GET,        9'd0,   32'h0,        1'b1, 1'b1, 32'hFFFFFFFF,
          9'd0, 9'd3},
        '{bolt_pkg::OP_GET,        9'd3,   32'h0,        1'b1, 1'b0, 32'h0, 9'd0, 9'd3},
        '{bolt_pkg::OP_FIND,       9'd0,   32'h0,        1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_SET,        9'd2,   32'h12345678, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_FIND,       9'd0,   32'hDEADBEEF, 1'b1, 1'b0, 32'h0, 9'd0, 9'd3},
        '{bolt_pkg::OP_INSERT_AT,  9'd3,   32'h80000000, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_REMOVE_ALL, 9'd0,   32'h80000000, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_REMOVE_ALL, 9'd0,   32'h55555555, 1'b1, 1'b1, 32'h0, 9'd0, 9'd2},
        '{bolt_pkg::OP_ERASE_AT,   9'd2,   32'h0,        1'b1, 1'b0, 32'h0, 9'd0, 9'd2},
        '{bolt_pkg::OP_ERASE_AT,   9'd0,   32'h0,        1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{OP_UNUSED,               9'd0,   32'hFFFFFFFF, 1'b1, 1'b0, 32'h0, 9'd0, 9'd1},
        '{bolt_pkg::OP_INSERT_AT,  9'd0,   32'hAAAAAAAA, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        // An equal value goes in front of its twin.
        '{bolt_pkg::OP_INSERT_ORD, 9'd0,   32'h12345678, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_REMOVE_ALL, 9'd0,   32'h12345678, 1'b0, 1'b0, 32'h0, 9'd0, 9'd0},
        '{bolt_pkg::OP_ERASE_AT,   9'd0,   32'h0,        1'b1, 1'b1, 32'h0, 9'd0, 9'd0}
    };

    bounded_ordered_list_table #(
        .CAPACITY    (LIST_CAPACITY),
        .VALUE_WIDTH (bolt_pkg::DATA_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the local list and returns the result the block
    // must produce for it.
    function automatic bolt_pkg::t_result list_step(
            input logic [2:0]                  op,
            input logic [bolt_pkg::POS_W-1:0]  pos,
            input logic [bolt_pkg::DATA_W-1:0] val);
        bolt_pkg::t_result r;
        int      i;
        int      w;
        int      removed;
        r = '0;
        case (op)
            bolt_pkg::OP_INSERT_AT: begin
                if (pos <= list_len && list_len < LIST_CAPACITY) begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_len++;
                    r.ok = 1'b1;
                end else if (list_len == LIST_CAPACITY) begin
                    full_refusals++;
                end
            end
            bolt_pkg::OP_INSERT_ORD: begin
                if (list_len < LIST_CAPACITY) begin
                    // Stop at the first entry less than or equal to the value.
                    i = 0;
                    while (i < list_len && list_mem[i] > val)
                        i++;
                    for (w = list_len; w > i; w--)
                        list_mem[w] = list_mem[w - 1];
                    list_mem[i] = val;
                    list_len++;
                    r.ok = 1'b1;
                end else begin
                    full_refusals++;
                end
            end
            bolt_pkg::OP_ERASE_AT: begin
                if (pos < list_len) begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            bolt_pkg::OP_REMOVE_ALL: begin
                w = 0;
                removed = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == val) begin
                        removed++;
                    end else begin
                        list_mem[w] = list_mem[i];
                        w++;
                    end
                end
                list_len = w;
                r.removed_count = removed[bolt_pkg::CNT_W-1:0];
                r.ok = 1'b1;
            end
            bolt_pkg::OP_GET: begin
                if (pos < list_len) begin
                    r.read_value = list_mem[pos];
                    r.ok = 1'b1;
                end
            end
            bolt_pkg::OP_SET: begin
                if (pos < list_len) begin
                    list_mem[pos] = val;
                    r.ok = 1'b1;
                end
            end
            bolt_pkg::OP_FIND: begin
                i = 0;
                while (i < list_len && list_mem[i] != val)
                    i++;
                if (i < list_len) begin
                    r.found_index = i[bolt_pkg::IDX_W-1:0];
                    r.ok = 1'b1;
                end
            end
            default: begin
                // The unused request code changes nothing and answers ok low.
            end
        endcase
        r.item_count = list_len[bolt_pkg::CNT_W-1:0];
        r.is_empty = (list_len == 0);
        if (list_len > peak_len)
            peak_len = list_len;
        return r;
    endfunction

    // Presents one request, waits for its transfer, then queues the result
    // it must produce: the typed one when given, otherwise the predicted one.
    task automatic send_request(input logic [2:0]                  op,
                                input logic [bolt_pkg::POS_W-1:0]  pos,
                                input logic [bolt_pkg::DATA_W-1:0] val,
                                input bit                          typed = 1'b0,
                                input bolt_pkg::t_result           typed_res = '0);
        bolt_pkg::t_result predicted;
        int      gap;
        int      idle_pct;
        idle_pct = (pace == PACE_SEND_GAPS) ? 77 : (pace == PACE_BOTH) ? 11 : 0;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, val, pos};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        predicted = list_step(op, pos, val);
        expected_results.push_back(typed ? typed_res : predicted);
        op_tally[op]++;
    endtask

    // Random requests biased to keep the list at a few dozen entries. Values
    // come from a small pool or from the list itself often enough to match.
    task automatic run_random_walk(input int n_items);
        logic [2:0]                  op;
        logic [bolt_pkg::POS_W-1:0]  pos;
        logic [bolt_pkg::DATA_W-1:0] val;
        int                          ins_w;
        int                          r;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            value_pool[k] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            ins_w = (list_len < 24) ? 40 : 16;
            r = $urandom_range(99);
            if (r < ins_w / 2)       op = bolt_pkg::OP_INSERT_AT;
            else if (r < ins_w)      op = bolt_pkg::OP_INSERT_ORD;
            else if (r < ins_w + 14) op = bolt_pkg::OP_ERASE_AT;
            else if (r < ins_w + 20) op = bolt_pkg::OP_REMOVE_ALL;
            else if (r < ins_w + 34) op = bolt_pkg::OP_GET;
            else if (r < ins_w + 46) op = bolt_pkg::OP_SET;
            else if (r < ins_w + 58) op = bolt_pkg::OP_FIND;
            else if (r < ins_w + 59) op = OP_UNUSED;
            else if (ins_w == 16)    op = bolt_pkg::OP_ERASE_AT;
            else                     op = bolt_pkg::OP_FIND;

            r = $urandom_range(99);
            if (r < 50)
                val = value_pool[$urandom_range(7)];
            else if (r < 65 && list_len > 0)
                val = list_mem[$urandom_range(list_len - 1)];
            else
                val = $urandom;

            // Mostly legal positions, then the one just past the end, then anything.
            r = $urandom_range(99);
            if (r < 75) begin
                if (op == bolt_pkg::OP_INSERT_AT)
                    pos = bolt_pkg::POS_W'($urandom_range(list_len));
                else
                    pos = (list_len > 0) ?
                          bolt_pkg::POS_W'($urandom_range(list_len - 1)) : '0;
            end else if (r < 87) begin
                pos = list_len[bolt_pkg::POS_W-1:0];
            end else begin
                pos = bolt_pkg::POS_W'($urandom_range(LIST_CAPACITY));
            end
            send_request(op, pos, val);
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [bolt_pkg::DATA_W-1:0] want,
                                        input logic [bolt_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result side: compares each transfer with the oldest expectation and
    // drives tready by pace mode, with an optional long hold.
    initial begin
        bolt_pkg::t_result got;
        bolt_pkg::t_result want;
        int      stall_pct;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                got = bolt_pkg::t_result'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with nothing outstanding, expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("found_index", want.found_index, got.found_index);
                    check_field("removed_count", want.removed_count, got.removed_count);
                    check_field("item_count", want.item_count, got.item_count);
                    check_field("is_empty", want.is_empty, got.is_empty);
                    results_checked++;
                end
            end
            stall_pct = (pace == PACE_RECV_STALLS) ? 77 : (pace == PACE_BOTH) ? 11 : 0;
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        logic [bolt_pkg::DATA_W-1:0] fill_value;
        logic [bolt_pkg::DATA_W-1:0] spare_value;
        bolt_pkg::t_result           typed_res;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            typed_res = '0;
            typed_res.ok = directed_rows[k].e_ok;
            typed_res.read_value = directed_rows[k].e_rd;
            typed_res.removed_count = directed_rows[k].e_rem;
            typed_res.item_count = directed_rows[k].e_cnt;
            typed_res.is_empty = (directed_rows[k].e_cnt == 0);
            send_request(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
                         directed_rows[k].chk, typed_res);
        end

        // Fill to capacity with one value while the result side holds off, so
        // the block backs up and drops s_axis_tready for a while.
        fill_value = $urandom;
        spare_value = ~fill_value;
        rx_hold_left = 400;
        while (list_len < LIST_CAPACITY) begin
            if ($urandom_range(1) == 1)
                send_request(bolt_pkg::OP_INSERT_AT,
                             bolt_pkg::POS_W'($urandom_range(list_len)), fill_value);
            else
                send_request(bolt_pkg::OP_INSERT_ORD,
                             bolt_pkg::POS_W'($urandom_range(LIST_CAPACITY)), fill_value);
        end
        send_request(bolt_pkg::OP_INSERT_AT, 9'd0, spare_value);
        send_request(bolt_pkg::OP_INSERT_AT, 9'd256, spare_value);
        send_request(bolt_pkg::OP_INSERT_ORD, 9'd0, spare_value);
        send_request(bolt_pkg::OP_GET, 9'd255, '0);
        send_request(bolt_pkg::OP_SET, 9'd255, spare_value);
        send_request(bolt_pkg::OP_FIND, 9'd0, spare_value);
        send_request(bolt_pkg::OP_FIND, 9'd0, fill_value);
        send_request(bolt_pkg::OP_GET, 9'd256, '0);
        send_request(bolt_pkg::OP_ERASE_AT, 9'd255, '0);
        send_request(bolt_pkg::OP_INSERT_AT, 9'd255, spare_value);
        send_request(bolt_pkg::OP_REMOVE_ALL, 9'd0, spare_value);
        send_request(bolt_pkg::OP_INSERT_ORD, 9'd0, fill_value);
        // Every entry now matches, so the whole list goes at once.
        send_request(bolt_pkg::OP_REMOVE_ALL, 9'd0, fill_value);
        send_request(bolt_pkg::OP_GET, 9'd0, '0);

        pace = PACE_STEADY;
        run_random_walk(390);
        pace = PACE_SEND_GAPS;
        run_random_walk(390);
        pace = PACE_RECV_STALLS;
        run_random_walk(390);
        pace = PACE_BOTH;
        run_random_walk(390);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: insert %0d, ordered %0d, erase %0d, remove-all %0d,",
                 results_checked, op_tally[bolt_pkg::OP_INSERT_AT],
                 op_tally[bolt_pkg::OP_INSERT_ORD], op_tally[bolt_pkg::OP_ERASE_AT],
                 op_tally[bolt_pkg::OP_REMOVE_ALL]);
        $display("get %0d, set %0d, find %0d, unused %0d; list peaked at %0d, %0d full refusals.",
                 op_tally[bolt_pkg::OP_GET], op_tally[bolt_pkg::OP_SET],
                 op_tally[bolt_pkg::OP_FIND], op_tally[OP_UNUSED], peak_len, full_refusals);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #60_000_000;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- bounded_ordered_list_table.f -----
+incdir+rtl/core
rtl/core/bolt_pkg.sv
rtl/core/bolt_mem.sv
rtl/core/bounded_ordered_list_table.sv
tb/sv/tb_bounded_ordered_list_table.sv
